// File: hdl/landmark_merge_table_unit_macros.svh
// Assertion macros for the landmark merge table unit.
`ifndef LANDMARK_MERGE_TABLE_UNIT_MACROS_SVH
`define LANDMARK_MERGE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, reset disables
`define LMT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset disables
`define LMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lmt_pkg.sv
// Shared types and constants of the landmark merge table unit.
package lmt_pkg;

   localparam int LMT_TABLE_DEPTH = 256;
   localparam int LMT_COORD_BITS  = 24;
   localparam int LMT_HIT_BITS    = 16;

   localparam int POS_W   = 24;
   localparam int HEAD_W  = 16;
   localparam int RIDX_W  = 8;
   localparam int HITS_W  = 16;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 16;
   localparam int CSRI_W  = 3;
   localparam int RAD_W   = 16;
   localparam int MINH_W  = 8;

   typedef enum logic [1:0] {
      FN_POSE = 2'd0,
      FN_DET  = 2'd1,
      FN_READ = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      OC_MERGED    = 3'd0,
      OC_APPENDED  = 3'd1,
      OC_DROPPED   = 3'd2,
      OC_IGNORED   = 3'd3,
      OC_POSE_READ = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      COL_UNKNOWN = 2'd0,
      COL_LEFT    = 2'd1,
      COL_RIGHT   = 2'd2
   } color_type;

   typedef enum logic [2:0] {
      CSR_MERGE_RADIUS   = 3'd0,
      CSR_MIN_HITS       = 3'd1,
      CSR_CLOSURE_RADIUS = 3'd2,
      CSR_MIN_CONFIRMED  = 3'd3,
      CSR_COLOR_ENABLE   = 3'd4,
      CSR_SKIP_RADIUS    = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_MERGE_RADIUS   = 16'd512;
   localparam logic [7:0]  RST_MIN_HITS       = 8'd3;
   localparam logic [15:0] RST_CLOSURE_RADIUS = 16'd3072;
   localparam logic [8:0]  RST_MIN_CONFIRMED  = 9'd20;
   localparam logic        RST_COLOR_ENABLE   = 1'b1;
   localparam logic [15:0] RST_SKIP_RADIUS    = 16'd10240;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SCAN,
      ST_MEAN_MUL,
      ST_MEAN_ADD,
      ST_MEAN_DIV,
      ST_COLOR_MUL,
      ST_COLOR_CMP,
      ST_WRITE,
      ST_CL_START,
      ST_CL_CNT,
      ST_CL_DIST,
      ST_OUT
   } state_type;

endpackage

// File: hdl/lmt_ram.sv
// Generic single-port-write, registered-read RAM.
module lmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lmt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lmt_div #(
   parameter int NW = 41,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    q_ff, q_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [DW:0]      shifted;
   logic [DW:0]      trial;

   assign shifted = {rem_ff, q_ff[NW-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW);
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// File: hdl/landmark_merge_table_unit.sv
// Landmark merge table unit: table scan, running mean and loop-closure sequencer.
// Pose and out-of-range read items go straight to the result; read items first read the entry.
// Detections: the scan of n entries runs through the distance pipeline (p1, p2, p3), and
// a merge updates the running mean in the shared divider (C coord, H hit bits), then color.
// Last-in-frame items then recount confirmed entries and check the distance to the start.
// One item at a time; synchronous active-high reset; the table keeps only a fill count.
`include "landmark_merge_table_unit_macros.svh"
module landmark_merge_table_unit #(
   parameter int TABLE_DEPTH = lmt_pkg::LMT_TABLE_DEPTH,
   parameter int COORD_BITS  = lmt_pkg::LMT_COORD_BITS,
   parameter int HIT_BITS    = lmt_pkg::LMT_HIT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [lmt_pkg::CSRI_W-1:0]        csr_index,
   input  logic [lmt_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic signed [lmt_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [lmt_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [lmt_pkg::POS_W-1:0]  req_pos_z,
   input  logic signed [lmt_pkg::HEAD_W-1:0] req_head_cos,
   input  logic signed [lmt_pkg::HEAD_W-1:0] req_head_sin,
   input  logic                              req_last_in_frame,
   input  logic [lmt_pkg::RIDX_W-1:0]        req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lmt_pkg::RIDX_W-1:0]        rsp_entry_index,
   output logic signed [lmt_pkg::POS_W-1:0]  rsp_entry_x,
   output logic signed [lmt_pkg::POS_W-1:0]  rsp_entry_y,
   output logic signed [lmt_pkg::POS_W-1:0]  rsp_entry_z,
   output logic [lmt_pkg::HITS_W-1:0]        rsp_entry_hits,
   output logic [1:0]                        rsp_entry_color,
   output logic [2:0]                        rsp_outcome,
   output logic                              rsp_entry_confirmed,
   output logic                              rsp_map_closed,
   output logic [lmt_pkg::COUNT_W-1:0]       rsp_entry_count
);

   import lmt_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int H     = HIT_BITS;
   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int W     = 3 * C + H + 2;
   localparam int X_LSB = 2 * C + H + 2;
   localparam int Y_LSB = C + H + 2;
   localparam int Z_LSB = H + 2;
   localparam int NW    = C + H + 1;
   localparam int DW    = H + 1;
   localparam int PW    = C + 17;

   state_type state_ff, state_in;

   // configuration
   logic [RAD_W-1:0]   merge_ff, clos_ff, skip_ff;
   logic [MINH_W-1:0]  minh_ff;
   logic [COUNT_W-1:0] minc_ff;
   logic               colen_ff;
   logic [31:0]        r2_ff, clos2_ff, skip2_ff;

   // block state
   logic [CW-1:0]         used_ff, used_in, conf_ff, conf_in, iss_ff, iss_in;
   logic                  pose_ff, pose_in, oset_ff, oset_in, closed_ff, closed_in;
   logic signed [C-1:0]   vx_ff, vx_in, vy_ff, vy_in, ox_ff, ox_in, oy_ff, oy_in;
   logic signed [HEAD_W-1:0] vcos_ff, vcos_in, vsin_ff, vsin_in;

   // working item
   logic signed [C-1:0]   dpx_ff, dpx_in, dpy_ff, dpy_in, dpz_ff, dpz_in;
   logic                  last_ff, last_in;
   logic [W-1:0]          od_ff, od_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic signed [C-1:0]   nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [H-1:0]          nh_ff, nh_in;
   logic [1:0]            ncol_ff, ncol_in;
   outcome_type           outc_ff, outc_in;
   logic                  ent_ff, ent_in;
   logic [1:0]            k_ff, k_in, wait_ff, wait_in;
   logic [C+H-1:0]        a_ff, a_in;
   logic [C-1:0]          b_ff, b_in;
   logic                  na_ff, na_in, nb_ff, nb_in, neg_ff, neg_in;
   logic signed [PW-1:0]  pa_ff, pa_in, pb_ff, pb_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in, rsp_load;

   // distance pipeline
   logic                  p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [AW-1:0]         p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [W-1:0]          p2_dat_ff, p3_dat_ff;
   logic [15:0]           p2_adx_ff, p2_ady_ff;
   logic                  p2_far_ff, p3_far_ff;
   logic [31:0]           p3_sqx_ff, p3_sqy_ff;

   // memory and divider
   logic                  ram_we, ram_re, issue;
   logic [AW-1:0]         ram_raddr;
   logic [W-1:0]          ram_rdata, ram_wdata;
   logic                  div_start, div_done;
   logic [NW-1:0]         div_num, div_quo;
   logic [DW-1:0]         div_den;

   // combinational helpers
   logic signed [C-1:0]   rd_x, rd_y, rd_z;
   logic [H-1:0]          rd_h;
   logic                  sel_cl;
   logic signed [C-1:0]   da_x, da_y, db_x, db_y;
   logic signed [C:0]     dfx, dfy;
   logic [C:0]            abx, aby;
   logic [32:0]           d2;
   logic                  hit;
   logic signed [C-1:0]   old_k, new_k;
   logic [C-1:0]          abs_old, abs_new;
   logic [NW-1:0]         a_e, b_e, mag;
   logic signed [C-1:0]   mean_res;
   logic [H-1:0]          h_old, h_sat;
   logic [1:0]            col_old;
   logic signed [C:0]     cdx, cdy;
   logic signed [PW:0]    cross_prod;
   logic [CW+RIDX_W-1:0]  rd_ix_w, used_w;
   logic                  rd_ok;

   assign rd_x = ram_rdata[X_LSB +: C];
   assign rd_y = ram_rdata[Y_LSB +: C];
   assign rd_z = ram_rdata[Z_LSB +: C];
   assign rd_h = ram_rdata[2 +: H];

   assign rd_ix_w = (CW + RIDX_W)'(req_read_index);
   assign used_w  = (CW + RIDX_W)'(used_ff);
   assign rd_ok   = rd_ix_w < used_w;

   // distance stage sources
   assign sel_cl = (state_ff == ST_CL_DIST) && (wait_ff == 2'd0);
   assign da_x   = sel_cl ? vx_ff : dpx_ff;
   assign da_y   = sel_cl ? vy_ff : dpy_ff;
   assign db_x   = sel_cl ? ox_ff : rd_x;
   assign db_y   = sel_cl ? oy_ff : rd_y;
   assign dfx    = {da_x[C-1], da_x} - {db_x[C-1], db_x};
   assign dfy    = {da_y[C-1], da_y} - {db_y[C-1], db_y};
   assign abx    = dfx[C] ? (C + 1)'(-dfx) : dfx;
   assign aby    = dfy[C] ? (C + 1)'(-dfy) : dfy;
   assign d2     = {1'b0, p3_sqx_ff} + {1'b0, p3_sqy_ff};
   assign hit    = p3_vld_ff && !p3_far_ff && (d2 < {1'b0, r2_ff});

   // running mean operands
   assign old_k   = (k_ff == 2'd0) ? od_ff[X_LSB +: C] :
                    (k_ff == 2'd1) ? od_ff[Y_LSB +: C] : od_ff[Z_LSB +: C];
   assign new_k   = (k_ff == 2'd0) ? dpx_ff : (k_ff == 2'd1) ? dpy_ff : dpz_ff;
   assign h_old   = od_ff[2 +: H];
   assign col_old = od_ff[1:0];
   assign h_sat   = (h_old == {H{1'b1}}) ? h_old : h_old + H'(1);
   assign abs_old = old_k[C-1] ? C'(-old_k) : old_k;
   assign abs_new = new_k[C-1] ? C'(-new_k) : new_k;
   assign a_e     = NW'(a_ff);
   assign b_e     = NW'(b_ff);
   assign div_num = mag;
   assign div_den = {1'b0, h_old} + DW'(1);
   assign mean_res = neg_ff ? C'(-div_quo[C-1:0]) : div_quo[C-1:0];

   always_comb begin
      if (na_ff == nb_ff) begin
         mag    = a_e + b_e;
         neg_in = na_ff;
      end else if (a_e >= b_e) begin
         mag    = a_e - b_e;
         neg_in = na_ff;
      end else begin
         mag    = b_e - a_e;
         neg_in = nb_ff;
      end
   end

   // side color
   assign cdx        = {nx_ff[C-1], nx_ff} - {vx_ff[C-1], vx_ff};
   assign cdy        = {ny_ff[C-1], ny_ff} - {vy_ff[C-1], vy_ff};
   assign cross_prod = {pa_ff[PW-1], pa_ff} - {pb_ff[PW-1], pb_ff};

   assign ram_wdata = {nx_ff, ny_ff, nz_ff, nh_ff, ncol_ff};

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      conf_in   = conf_ff;
      iss_in    = iss_ff;
      pose_in   = pose_ff;
      oset_in   = oset_ff;
      closed_in = closed_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      vcos_in   = vcos_ff;
      vsin_in   = vsin_ff;
      dpx_in    = dpx_ff;
      dpy_in    = dpy_ff;
      dpz_in    = dpz_ff;
      last_in   = last_ff;
      od_in     = od_ff;
      idx_in    = idx_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      nz_in     = nz_ff;
      nh_in     = nh_ff;
      ncol_in   = ncol_ff;
      outc_in   = outc_ff;
      ent_in    = ent_ff;
      k_in      = k_ff;
      wait_in   = wait_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = iss_ff[AW-1:0];
      issue     = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dpx_in  = C'(req_pos_x);
               dpy_in  = C'(req_pos_y);
               dpz_in  = C'(req_pos_z);
               last_in = req_last_in_frame;
               ent_in  = 1'b0;
               idx_in  = '0;
               case (req_func)
                  FN_POSE: begin
                     vx_in    = C'(req_pos_x);
                     vy_in    = C'(req_pos_y);
                     vcos_in  = req_head_cos;
                     vsin_in  = req_head_sin;
                     pose_in  = 1'b1;
                     outc_in  = OC_POSE_READ;
                     state_in = ST_OUT;
                  end
                  FN_READ: begin
                     outc_in = OC_POSE_READ;
                     if (rd_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = rd_ix_w[AW-1:0];
                        idx_in    = rd_ix_w[AW-1:0];
                        state_in  = ST_RD_WAIT;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  FN_DET: begin
                     if (pose_ff && !closed_ff) begin
                        iss_in   = '0;
                        state_in = ST_SCAN;
                     end else begin
                        outc_in  = OC_IGNORED;
                        state_in = ST_OUT;
                     end
                  end
                  default: begin
                     outc_in  = OC_IGNORED;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            nx_in    = rd_x;
            ny_in    = rd_y;
            nz_in    = rd_z;
            nh_in    = rd_h;
            ncol_in  = ram_rdata[1:0];
            ent_in   = 1'b1;
            state_in = ST_OUT;
         end
         ST_SCAN: begin
            if (hit) begin
               od_in    = p3_dat_ff;
               idx_in   = p3_idx_ff;
               k_in     = 2'd0;
               state_in = ST_MEAN_MUL;
            end else if (iss_ff < used_ff) begin
               ram_re = 1'b1;
               issue  = 1'b1;
               iss_in = iss_ff + CW'(1);
            end else if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               if (used_ff < CW'(TABLE_DEPTH)) begin
                  idx_in  = used_ff[AW-1:0];
                  nx_in   = dpx_ff;
                  ny_in   = dpy_ff;
                  nz_in   = dpz_ff;
                  nh_in   = H'(1);
                  ncol_in = COL_UNKNOWN;
                  ent_in  = 1'b1;
                  outc_in = OC_APPENDED;
                  used_in = used_ff + CW'(1);
                  if (!oset_ff && used_ff == '0) begin
                     ox_in   = vx_ff;
                     oy_in   = vy_ff;
                     oset_in = 1'b1;
                  end
                  state_in = colen_ff ? ST_COLOR_MUL : ST_WRITE;
               end else begin
                  outc_in  = OC_DROPPED;
                  ent_in   = 1'b0;
                  state_in = last_ff ? ST_CL_START : ST_OUT;
               end
            end
         end
         ST_MEAN_MUL: begin
            a_in     = (C + H)'(abs_old) * (C + H)'(h_old);
            b_in     = abs_new;
            na_in    = old_k[C-1] && (h_old != '0);
            nb_in    = new_k[C-1];
            state_in = ST_MEAN_ADD;
         end
         ST_MEAN_ADD: begin
            div_start = 1'b1;
            state_in  = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            if (div_done) begin
               case (k_ff)
                  2'd0:    nx_in = mean_res;
                  2'd1:    ny_in = mean_res;
                  default: nz_in = mean_res;
               endcase
               if (k_ff == 2'd2) begin
                  nh_in   = h_sat;
                  ncol_in = col_old;
                  ent_in  = 1'b1;
                  outc_in = OC_MERGED;
                  if (col_old == COL_UNKNOWN && colen_ff) begin
                     state_in = ST_COLOR_MUL;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_MEAN_MUL;
               end
            end
         end
         ST_COLOR_MUL: begin
            pa_in    = PW'(vcos_ff) * PW'(cdy);
            pb_in    = PW'(vsin_ff) * PW'(cdx);
            state_in = ST_COLOR_CMP;
         end
         ST_COLOR_CMP: begin
            ncol_in  = (!cross_prod[PW] && cross_prod != '0) ? COL_LEFT : COL_RIGHT;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ram_we   = 1'b1;
            state_in = last_ff ? ST_CL_START : ST_OUT;
         end
         ST_CL_START: begin
            if (!oset_ff) begin
               state_in = ST_OUT;
            end else begin
               iss_in   = '0;
               conf_in  = '0;
               state_in = ST_CL_CNT;
            end
         end
         ST_CL_CNT: begin
            if (p1_vld_ff && ((H + MINH_W)'(rd_h) >= (H + MINH_W)'(minh_ff))) begin
               conf_in = conf_ff + CW'(1);
            end
            if (iss_ff < used_ff) begin
               ram_re = 1'b1;
               issue  = 1'b1;
               iss_in = iss_ff + CW'(1);
            end else if (!p1_vld_ff) begin
               if ((CW + COUNT_W)'(conf_ff) < (CW + COUNT_W)'(minc_ff)) begin
                  state_in = ST_OUT;
               end else begin
                  wait_in  = 2'd0;
                  state_in = ST_CL_DIST;
               end
            end
         end
         ST_CL_DIST: begin
            wait_in = wait_ff + 2'd1;
            if (wait_ff == 2'd2) begin
               if (!p3_far_ff && d2 >= {1'b0, skip2_ff} && d2 < {1'b0, clos2_ff}) begin
                  closed_in = 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         conf_ff      <= '0;
         iss_ff       <= '0;
         pose_ff      <= 1'b0;
         oset_ff      <= 1'b0;
         closed_ff    <= 1'b0;
         vx_ff        <= '0;
         vy_ff        <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         vcos_ff      <= '0;
         vsin_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         merge_ff     <= RST_MERGE_RADIUS;
         minh_ff      <= RST_MIN_HITS;
         clos_ff      <= RST_CLOSURE_RADIUS;
         minc_ff      <= RST_MIN_CONFIRMED;
         colen_ff     <= RST_COLOR_ENABLE;
         skip_ff      <= RST_SKIP_RADIUS;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         conf_ff      <= conf_in;
         iss_ff       <= iss_in;
         pose_ff      <= pose_in;
         oset_ff      <= oset_in;
         closed_ff    <= closed_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         vcos_ff      <= vcos_in;
         vsin_ff      <= vsin_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_vld_ff    <= issue;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         if (csr_write_en) begin
            case (csr_index)
               CSR_MERGE_RADIUS:   merge_ff <= csr_wdata;
               CSR_MIN_HITS:       minh_ff  <= csr_wdata[MINH_W-1:0];
               CSR_CLOSURE_RADIUS: clos_ff  <= csr_wdata;
               CSR_MIN_CONFIRMED:  minc_ff  <= csr_wdata[COUNT_W-1:0];
               CSR_COLOR_ENABLE:   colen_ff <= csr_wdata[0];
               CSR_SKIP_RADIUS:    skip_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dpx_ff    <= dpx_in;
      dpy_ff    <= dpy_in;
      dpz_ff    <= dpz_in;
      last_ff   <= last_in;
      od_ff     <= od_in;
      idx_ff    <= idx_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      nh_ff     <= nh_in;
      ncol_ff   <= ncol_in;
      outc_ff   <= outc_in;
      ent_ff    <= ent_in;
      k_ff      <= k_in;
      wait_ff   <= wait_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      neg_ff    <= neg_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      r2_ff     <= 32'(merge_ff) * 32'(merge_ff);
      clos2_ff  <= 32'(clos_ff) * 32'(clos_ff);
      skip2_ff  <= 32'(skip_ff) * 32'(skip_ff);
      p1_idx_ff <= iss_ff[AW-1:0];
      p2_idx_ff <= p1_idx_ff;
      p2_dat_ff <= ram_rdata;
      p2_adx_ff <= abx[15:0];
      p2_ady_ff <= aby[15:0];
      p2_far_ff <= (abx[C:16] != '0) || (aby[C:16] != '0);
      p3_idx_ff <= p2_idx_ff;
      p3_dat_ff <= p2_dat_ff;
      p3_sqx_ff <= 32'(p2_adx_ff) * 32'(p2_adx_ff);
      p3_sqy_ff <= 32'(p2_ady_ff) * 32'(p2_ady_ff);
      p3_far_ff <= p2_far_ff;
      if (rsp_load) begin
         rsp_entry_index     <= ent_ff ? RIDX_W'(idx_ff) : '0;
         rsp_entry_x         <= ent_ff ? POS_W'(nx_ff) : '0;
         rsp_entry_y         <= ent_ff ? POS_W'(ny_ff) : '0;
         rsp_entry_z         <= ent_ff ? POS_W'(nz_ff) : '0;
         rsp_entry_hits      <= ent_ff ? HITS_W'(nh_ff) : '0;
         rsp_entry_color     <= ent_ff ? ncol_ff : '0;
         rsp_outcome         <= outc_ff;
         rsp_entry_confirmed <= ent_ff &&
                                ((H + MINH_W)'(nh_ff) >= (H + MINH_W)'(minh_ff));
         rsp_map_closed      <= closed_ff;
         rsp_entry_count     <= COUNT_W'(used_ff);
      end
   end

   lmt_ram #(
      .WIDTH (W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lmt_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `LMT_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= CW'(TABLE_DEPTH), "fill count beyond depth")
   `LMT_ASSERT_NEXT(a_closed_sticky, closed_ff, closed_ff, "closure flag dropped")
   `LMT_ASSERT_NEXT(a_used_step, 1'b1, used_ff - $past(used_ff) <= CW'(1), "fill count jumped")
   `LMT_ASSERT_NOW(a_div_owner, div_done, state_ff == ST_MEAN_DIV, "divider done outside mean")

endmodule

// File: verif/landmark_merge_table_unit_test.sv
// Self-checking testbench of the landmark merge table unit: directed and random items.
module landmark_merge_table_unit_test;
   import lmt_pkg::*;

   localparam int IDLE_LIMIT = 6000;

   typedef struct {
      logic [1:0]         func;
      logic signed [23:0] px, py, pz;
      logic signed [15:0] hc, hs;
      logic               last;
      logic [7:0]         ridx;
   } landmark_item_type;

   typedef struct packed {
      logic [7:0]  idx;
      logic [23:0] x, y, z;
      logic [15:0] hits;
      logic [1:0]  color;
      logic [2:0]  oc;
      logic        conf, closed;
      logic [8:0]  cnt;
   } landmark_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [CSRI_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_func = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [HEAD_W-1:0] req_head_cos = '0, req_head_sin = '0;
   logic req_last_in_frame = 0;
   logic [RIDX_W-1:0] req_read_index = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [RIDX_W-1:0] rsp_entry_index;
   logic signed [POS_W-1:0] rsp_entry_x, rsp_entry_y, rsp_entry_z;
   logic [HITS_W-1:0] rsp_entry_hits;
   logic [1:0] rsp_entry_color;
   logic [2:0] rsp_outcome;
   logic rsp_entry_confirmed, rsp_map_closed;
   logic [COUNT_W-1:0] rsp_entry_count;

   landmark_merge_table_unit uut (.*);

   always #6 clock = ~clock;

   // table model
   longint tab_px [256], tab_py [256], tab_pz [256];
   longint unsigned tab_hits [256];
   logic [1:0] tab_color [256];
   int unsigned fill_count, confirmed_total;
   longint veh_px, veh_py, veh_c, veh_s, start_px, start_py;
   bit have_pose, have_start, loop_closed;
   longint unsigned merge_r, hits_needed, closure_r, confirmed_needed, color_on, skip_r;

   landmark_item_type pending_items [$];
   landmark_result_type expected_results [$];
   int issued, checked, mismatches, unexpected;
   int n_merged, n_appended, n_dropped, n_ignored;
   bit req_taken;
   int idle_cycles;
   int centers_x [64], centers_y [64];

   function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > 65535 || dy > 65535) return '1;
      return longint'(dx * dx + dy * dy);
   endfunction

   function automatic longint wrap_coord(longint v);
      logic signed [23:0] t;
      t = v[23:0];
      return longint'(t);
   endfunction

   function automatic longint mean_update(longint old, longint unsigned h, longint nw);
      longint unsigned a, b, mag;
      bit na, nb, neg;
      a = longint'(old < 0 ? -old : old) * h;
      b = longint'(nw < 0 ? -nw : nw);
      na = old < 0 && h != 0;
      nb = nw < 0;
      if (na == nb) begin
         mag = a + b; neg = na;
      end else if (a >= b) begin
         mag = a - b; neg = na;
      end else begin
         mag = b - a; neg = nb;
      end
      mag = mag / (h + 1);
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [1:0] side_of(longint ex, longint ey);
      longint side_val;
      side_val = veh_c * (ey - veh_py) - veh_s * (ex - veh_px);
      return side_val > 0 ? COL_LEFT : COL_RIGHT;
   endfunction

   function automatic bit closure_check();
      int unsigned n;
      longint unsigned d;
      n = 0;
      if (!have_start) return 0;
      for (int i = 0; i < fill_count; i++)
         if (tab_hits[i] >= hits_needed) n++;
      confirmed_total = n;
      if (n < confirmed_needed) return 0;
      d = sq_dist(veh_px, veh_py, start_px, start_py);
      if (d == '1) return 0;
      if (d < skip_r * skip_r) return 0;
      return d < closure_r * closure_r;
   endfunction

   function automatic void load_entry(ref landmark_result_type r, input int i);
      r.idx = i[7:0];
      r.x = tab_px[i][23:0];
      r.y = tab_py[i][23:0];
      r.z = tab_pz[i][23:0];
      r.hits = tab_hits[i][15:0];
      r.color = tab_color[i];
      r.conf = tab_hits[i] >= hits_needed;
   endfunction

   function automatic landmark_result_type predict_landmark(landmark_item_type it);
      landmark_result_type r;
      longint px, py, pz;
      longint unsigned r2, h;
      bit done;
      r = '{idx: 0, x: 0, y: 0, z: 0, hits: 0, color: COL_UNKNOWN, oc: OC_IGNORED,
            conf: 0, closed: 0, cnt: 0};
      px = it.px;
      py = it.py;
      pz = it.pz;
      done = 0;
      if (it.func == FN_POSE) begin
         veh_px = px; veh_py = py; veh_c = it.hc; veh_s = it.hs;
         have_pose = 1;
         r.oc = OC_POSE_READ;
      end else if (it.func == FN_READ) begin
         if (it.ridx < fill_count) load_entry(r, it.ridx);
         r.oc = OC_POSE_READ;
      end else if (it.func == FN_DET && have_pose && !loop_closed) begin
         r2 = merge_r * merge_r;
         for (int i = 0; i < fill_count && !done; i++) begin
            if (sq_dist(px, py, tab_px[i], tab_py[i]) < r2) begin
               h = tab_hits[i];
               tab_px[i] = wrap_coord(mean_update(tab_px[i], h, px));
               tab_py[i] = wrap_coord(mean_update(tab_py[i], h, py));
               tab_pz[i] = wrap_coord(mean_update(tab_pz[i], h, pz));
               tab_hits[i] = h < 65535 ? h + 1 : 65535;
               if (tab_color[i] == COL_UNKNOWN && color_on != 0)
                  tab_color[i] = side_of(tab_px[i], tab_py[i]);
               load_entry(r, i);
               r.oc = OC_MERGED;
               done = 1;
            end
         end
         if (!done) begin
            if (fill_count < 256) begin
               tab_px[fill_count] = px;
               tab_py[fill_count] = py;
               tab_pz[fill_count] = pz;
               tab_hits[fill_count] = 1;
               tab_color[fill_count] = color_on != 0 ? side_of(px, py) : COL_UNKNOWN;
               fill_count++;
               if (!have_start && fill_count == 1) begin
                  start_px = veh_px; start_py = veh_py; have_start = 1;
               end
               load_entry(r, fill_count - 1);
               r.oc = OC_APPENDED;
            end else begin
               r.oc = OC_DROPPED;
            end
         end
         if (it.last && closure_check()) loop_closed = 1;
      end
      r.closed = loop_closed;
      r.cnt = fill_count[8:0];
      return r;
   endfunction

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         CSR_MERGE_RADIUS:   merge_r = val & 16'hFFFF;
         CSR_MIN_HITS:       hits_needed = val & 8'hFF;
         CSR_CLOSURE_RADIUS: closure_r = val & 16'hFFFF;
         CSR_MIN_CONFIRMED:  confirmed_needed = val & 9'h1FF;
         CSR_COLOR_ENABLE:   color_on = val & 1;
         CSR_SKIP_RADIUS:    skip_r = val & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic push_item(logic [1:0] f, int x, int y, int z, int c, int s, bit l, int ri);
      landmark_item_type it;
      it.func = f; it.px = x[23:0]; it.py = y[23:0]; it.pz = z[23:0];
      it.hc = c[15:0]; it.hs = s[15:0]; it.last = l; it.ridx = ri[7:0];
      pending_items = {pending_items, it};
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_items.size() != 0 || issued != checked) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic int rand_head();
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   task automatic push_random(int n, int ncent, int spread, int near_start);
      int r, k, x, y;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         k = $urandom_range(0, ncent - 1);
         if (r < 8) begin
            if (near_start != 0) begin
               x = int'($urandom_range(0, 40000)) - 20000;
               y = int'($urandom_range(0, 40000)) - 20000;
            end else begin
               x = centers_x[k]; y = centers_y[k];
            end
            push_item(FN_POSE, x, y, $urandom, rand_head(), rand_head(), $urandom, $urandom);
         end else if (r < 16) begin
            push_item(FN_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 255));
         end else if (r < 18) begin
            push_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            x = centers_x[k] + int'($urandom_range(0, 2 * spread)) - spread;
            y = centers_y[k] + int'($urandom_range(0, 2 * spread)) - spread;
            push_item(FN_DET, x, y, $urandom, $urandom, $urandom,
                      $urandom_range(0, 5) == 0, $urandom);
         end
      end
   endtask

   // sender
   int gap_left = 0, gap_mode = 0;
   always @(negedge clock) begin : sender
      landmark_item_type it;
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            issued++;
            req_func <= it.func;
            req_pos_x <= it.px;
            req_pos_y <= it.py;
            req_pos_z <= it.pz;
            req_head_cos <= it.hc;
            req_head_sin <= it.hs;
            req_last_in_frame <= it.last;
            req_read_index <= it.ridx;
            req_valid <= 1;
            if ($urandom_range(0, 60) == 0) gap_mode = !gap_mode;
            if (gap_mode) gap_left = 0;
            else if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(20, 300);
            else gap_left = $urandom_range(0, 3);
         end else begin
            req_valid <= 0;
         end
         req_taken = 0;
      end
   end

   // receiver back-pressure
   int stall_left = 0, stall_mode = 0;
   always @(negedge clock) begin : receiver
      int r;
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if ($urandom_range(0, 400) == 0) stall_mode = !stall_mode;
            r = $urandom_range(0, 99);
            if (!stall_mode && r < 20) stall_left = r < 2 ? $urandom_range(20, 300)
                                                          : $urandom_range(1, 3);
         end
      end
   end

   // result check and request capture
   always @(posedge clock) begin : monitor
      landmark_result_type want, got;
      landmark_item_type it;
      bit moved;
      if (!reset) begin
         moved = 0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1;
            got = '{idx: rsp_entry_index, x: rsp_entry_x, y: rsp_entry_y, z: rsp_entry_z,
                    hits: rsp_entry_hits, color: rsp_entry_color, oc: rsp_outcome,
                    conf: rsp_entry_confirmed, closed: rsp_map_closed, cnt: rsp_entry_count};
            if (expected_results.size() == 0) begin
               unexpected++;
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: outcome %0d", got.oc);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch #%0d exp idx %0d x %h y %h z %h hits %0d col %0d",
                              checked, want.idx, want.x, want.y, want.z, want.hits,
                              want.color);
                     $display("   exp oc %0d conf %b cl %b cnt %0d",
                              want.oc, want.conf, want.closed, want.cnt);
                     $display("   got idx %0d x %h y %h z %h hits %0d col %0d",
                              got.idx, got.x, got.y, got.z, got.hits, got.color);
                     $display("   got oc %0d conf %b cl %b cnt %0d",
                              got.oc, got.conf, got.closed, got.cnt);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1;
            it = '{func: req_func, px: req_pos_x, py: req_pos_y, pz: req_pos_z,
                   hc: req_head_cos, hs: req_head_sin, last: req_last_in_frame,
                   ridx: req_read_index};
            want = predict_landmark(it);
            case (want.oc)
               OC_MERGED:   n_merged++;
               OC_APPENDED: n_appended++;
               OC_DROPPED:  n_dropped++;
               OC_IGNORED:  n_ignored++;
               default: ;
            endcase
            expected_results = {expected_results, want};
            req_taken = 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      merge_r = RST_MERGE_RADIUS; hits_needed = RST_MIN_HITS;
      closure_r = RST_CLOSURE_RADIUS; confirmed_needed = RST_MIN_CONFIRMED;
      color_on = RST_COLOR_ENABLE; skip_r = RST_SKIP_RADIUS;
      for (int i = 0; i < 64; i++) begin
         centers_x[i] = int'($urandom_range(0, 16000000)) - 8000000;
         centers_y[i] = int'($urandom_range(0, 16000000)) - 8000000;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty table, before pose, unused func, extremes, merges, reads
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 0);
      push_item(FN_DET, 100, 100, 100, 0, 0, 1, 0);
      push_item(2'd3, -1, -1, -1, -1, -1, 1, 255);
      push_item(FN_POSE, 0, 0, 0, 16384, 0, 0, 0);
      push_item(FN_DET, 1000, 2000, -8388608, 0, 0, 1, 0);
      push_item(FN_DET, 1100, 2050, 8388607, 0, 0, 0, 0);
      push_item(FN_DET, 1050, 1990, 5, 0, 0, 0, 0);
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 0);
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 255);
      push_item(FN_POSE, 8388607, -8388608, 0, -16384, 16384, 0, 0);
      push_item(FN_DET, 8388607, -8388608, 0, 0, 0, 0, 0);
      push_item(FN_DET, 8388600, -8388600, 100, 0, 0, 1, 0);
      push_item(FN_POSE, -8388608, 8388607, 0, 0, -16384, 0, 0);
      push_item(FN_DET, -8388608, 8388607, -1, 0, 0, 1, 0);
      push_item(FN_POSE, 0, 0, 0, 11585, -11585, 0, 0);
      push_item(FN_DET, -3000, 500, 77, 0, 0, 0, 0);
      push_item(FN_DET, 3000, -500, -77, 0, 0, 1, 0);
      push_item(FN_DET, 1020, 2010, 0, 0, 0, 0, 0);
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 1);
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 3);
      push_item(FN_READ, 0, 0, 0, 0, 0, 0, 4);
      drain();

      write_reg(CSR_MERGE_RADIUS, 800);
      write_reg(CSR_MIN_HITS, 1);
      write_reg(CSR_COLOR_ENABLE, 0);
      write_reg(CSR_MIN_CONFIRMED, 256);
      write_reg(CSR_SKIP_RADIUS, 65535);
      write_reg(CSR_CLOSURE_RADIUS, 0);
      push_random(300, 12, 1500, 0);
      drain();

      // radius zero: every detection appends until the table is full
      write_reg(CSR_MERGE_RADIUS, 0);
      write_reg(CSR_MIN_HITS, 255);
      write_reg(CSR_COLOR_ENABLE, 1);
      push_random(400, 64, 30000, 0);
      drain();

      write_reg(CSR_MERGE_RADIUS, 65535);
      write_reg(CSR_MIN_HITS, 2);
      write_reg(CSR_MIN_CONFIRMED, 0);
      push_random(250, 64, 40000, 0);
      drain();

      // loop closure near the start pose
      write_reg(CSR_MERGE_RADIUS, 3000);
      write_reg(CSR_MIN_HITS, 1);
      write_reg(CSR_MIN_CONFIRMED, 10);
      write_reg(CSR_SKIP_RADIUS, 0);
      write_reg(CSR_CLOSURE_RADIUS, 65535);
      write_reg(CSR_COLOR_ENABLE, 0);
      push_random(250, 64, 3000, 1);
      drain();

      repeat (50) @(negedge clock);
      $display("covered %0d items: %0d merged, %0d appended, %0d dropped, %0d ignored",
               checked, n_merged, n_appended, n_dropped, n_ignored);
      $display("table held %0d entries, loop closed %0d, unexpected results %0d",
               fill_count, loop_closed, unexpected);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lmt_pkg.sv
hdl/lmt_ram.sv
hdl/lmt_div.sv
hdl/landmark_merge_table_unit.sv
verif/landmark_merge_table_unit_test.sv
